@@ rtl/sst_pkg.sv @@
// Shared types and codes for the sorted set table.
package sst_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;
  localparam int COUNT_W      = 5;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

@@ rtl/sst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sorted_set_table_core.sv @@
// Sorted set table: ordered table of distinct signed values in one RAM.
//
//   channel  signals                 direction  content
//   req      req_valid/req_stall/req in         operation kind and value
//   rsp      rsp_valid/rsp_stall/rsp out        success, status, entry count
//
// One transaction at a time. A linear scan through the RAM (one entry per
// cycle, registered read) finds the slot at position p. An insert then moves
// (count - p) entries up, a remove (count - p - 1) down, one RAM write per
// cycle. rst clears the count; the table contents need no clearing.
// req is stalled while a transaction is in progress; a finished result waits
// in the rsp register until taken.
module sorted_set_table_core #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sst_pkg::rsp_t rsp
);
  import sst_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHUP   = 3'd3;
  localparam logic [2:0] S_WRV    = 3'd4;
  localparam logic [2:0] S_SHDN   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]               state, state_next;
  logic [1:0]               kind, kind_next;
  logic signed [DATA_W-1:0] value, value_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [CNT_W-1:0]         pos, pos_next;
  logic [CNT_W-1:0]         cursor, cursor_next;
  logic [CNT_W-1:0]         occupied, occupied_next;
  logic                     present, present_next;
  logic                     success, success_next;
  logic [1:0]               status, status_next;
  logic                     rsp_valid_next;
  rsp_t                     rsp_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W:0]   cursor_plus2;
  logic [CNT_W-1:0] occ_new;

  sst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req_stall    = (state != S_IDLE);
  assign idx_inc      = idx + 1'b1;
  assign cursor_plus2 = {1'b0, cursor} + (CNT_W+1)'(2);

  always_comb begin
    case (kind)
      KIND_INSERT: occ_new = success ? occupied + 1'b1 : occupied;
      KIND_REMOVE: occ_new = success ? occupied - 1'b1 : occupied;
      default:     occ_new = occupied;
    endcase
  end

  always_comb begin
    state_next     = state;
    kind_next      = kind;
    value_next     = value;
    idx_next       = idx;
    pos_next       = pos;
    cursor_next    = cursor;
    occupied_next  = occupied;
    present_next   = present;
    success_next   = success;
    status_next    = status;
    rsp_valid_next = rsp_valid;
    rsp_next       = rsp;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = value;
    ram_raddr      = '0;

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          kind_next  = req.kind;
          value_next = req.value;
          idx_next   = '0;
          if (occupied == '0) begin
            pos_next     = '0;
            present_next = 1'b0;
            state_next   = S_DECIDE;
          end else begin
            ram_raddr  = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // ram_rdata holds entry idx
        if ($signed(ram_rdata) >= value) begin
          pos_next     = idx;
          present_next = ($signed(ram_rdata) == value);
          state_next   = S_DECIDE;
        end else if (idx_inc == occupied) begin
          pos_next     = occupied;
          present_next = 1'b0;
          state_next   = S_DECIDE;
        end else begin
          idx_next  = idx_inc;
          ram_raddr = IDX_W'(idx_inc);
        end
      end
      S_DECIDE: begin
        success_next = 1'b0;
        status_next  = ST_MISS;
        state_next   = S_DONE;
        case (kind)
          KIND_INSERT: begin
            if (present) begin
              status_next = ST_MISS;
            end else if (occupied == CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              success_next = 1'b1;
              status_next  = ST_DONE;
              if (pos == occupied) begin
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(pos);
                ram_wdata  = value;
              end else begin
                cursor_next = occupied;
                ram_raddr   = IDX_W'(occupied - 1'b1);
                state_next  = S_SHUP;
              end
            end
          end
          KIND_REMOVE: begin
            if (present) begin
              success_next = 1'b1;
              status_next  = ST_DONE;
              if ((pos + 1'b1) < occupied) begin
                cursor_next = pos;
                ram_raddr   = IDX_W'(pos + 1'b1);
                state_next  = S_SHDN;
              end
            end
          end
          default: begin
            if (present) begin
              success_next = 1'b1;
              status_next  = ST_DONE;
            end
          end
        endcase
      end
      S_SHUP: begin
        // move entry cursor-1 up to cursor
        ram_we      = 1'b1;
        ram_waddr   = IDX_W'(cursor);
        ram_wdata   = ram_rdata;
        cursor_next = cursor - 1'b1;
        if ((cursor - 1'b1) == pos) begin
          state_next = S_WRV;
        end else begin
          ram_raddr = IDX_W'(cursor - CNT_W'(2));
        end
      end
      S_WRV: begin
        ram_we     = 1'b1;
        ram_waddr  = IDX_W'(pos);
        ram_wdata  = value;
        state_next = S_DONE;
      end
      S_SHDN: begin
        // move entry cursor+1 down to cursor
        ram_we      = 1'b1;
        ram_waddr   = IDX_W'(cursor);
        ram_wdata   = ram_rdata;
        cursor_next = cursor + 1'b1;
        if (cursor_plus2 < {1'b0, occupied}) begin
          ram_raddr = IDX_W'(cursor_plus2);
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next       = 1'b1;
          rsp_next.success     = success;
          rsp_next.status      = status;
          rsp_next.entry_count = COUNT_W'(occ_new);
          occupied_next        = occ_new;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupied  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupied  <= occupied_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind    <= kind_next;
    value   <= value_next;
    idx     <= idx_next;
    pos     <= pos_next;
    cursor  <= cursor_next;
    present <= present_next;
    success <= success_next;
    status  <= status_next;
    rsp     <= rsp_next;
  end

endmodule

@@ tb/tb_sorted_set_table_core.sv @@
// Self-checking testbench for the sorted set table core: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_sorted_set_table_core;
  import sst_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, behaves as a lookup
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_PER_PHASE = 106;
  localparam int SETTLE_CYCLES = 3 * CAPACITY + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [DATA_W-1:0]  value;
    logic               typed;
    logic               success;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } op_row_t;

  // typed = 1: expected result given in the row; typed = 0: left to the table model
  op_row_t directed_rows [27] = '{
    '{KIND_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, ST_MISS, 5'd0},
    '{KIND_SPARE,  32'h0000_0000, 1'b1, 1'b0, ST_MISS, 5'd0},
    '{KIND_REMOVE, 32'hffff_ffff, 1'b1, 1'b0, ST_MISS, 5'd0},
    '{KIND_INSERT, 32'h8000_0000, 1'b1, 1'b1, ST_DONE, 5'd1},
    '{KIND_INSERT, 32'h7fff_ffff, 1'b1, 1'b1, ST_DONE, 5'd2},
    '{KIND_INSERT, 32'h8000_0000, 1'b1, 1'b0, ST_MISS, 5'd2},
    '{KIND_LOOKUP, 32'h7fff_ffff, 1'b1, 1'b1, ST_DONE, 5'd2},
    '{KIND_REMOVE, 32'h8000_0000, 1'b1, 1'b1, ST_DONE, 5'd1},
    // fill to capacity, out of order
    '{KIND_INSERT, 32'hffff_ffff, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h0000_0000, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h0000_0001, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h8000_0000, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h7fff_fffe, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h8000_0001, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h5555_5555, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'haaaa_aaaa, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h0000_0064, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'hffff_ff9c, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h0000_ffff, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'hffff_0000, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h0000_002a, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'hffff_ffd6, 1'b0, 1'b0, ST_DONE, 5'd0},
    '{KIND_INSERT, 32'h0000_0007, 1'b0, 1'b0, ST_DONE, 5'd0},
    // full table: new value refused, duplicate still reported as such
    '{KIND_INSERT, 32'h0000_0003, 1'b1, 1'b0, ST_FULL, 5'd16},
    '{KIND_INSERT, 32'h0000_0000, 1'b1, 1'b0, ST_MISS, 5'd16},
    '{KIND_REMOVE, 32'h7fff_ffff, 1'b1, 1'b1, ST_DONE, 5'd15},
    '{KIND_SPARE,  32'h0000_002a, 1'b0, 1'b0, ST_DONE, 5'd0}
  };

  int send_idle_by_phase  [4] = '{0, 64, 0, 17};
  int recv_stall_by_phase [4] = '{0, 0, 64, 17};

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  // table model
  logic signed [DATA_W-1:0] set_vals [CAPACITY];
  int                       set_count = 0;

  op_row_t     op_queue [$];
  rsp_t        pending_rsps [$];
  logic [DATA_W-1:0] value_pool [POOL_SIZE];

  logic  cur_typed = 1'b0;
  rsp_t  cur_want = '0;
  op_row_t next_row;
  rsp_t  model_rsp;
  rsp_t  got_want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int full_refusals = 0;
  int empty_results = 0;
  int quiet_cycles = 0;

  sorted_set_table_core #(.CAPACITY(CAPACITY)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Applies one operation to the table model and returns its result.
  function automatic rsp_t apply_set_op(req_t op);
    rsp_t                     r;
    logic signed [DATA_W-1:0] v;
    int                       pos;
    bit                       present;
    v = op.value;
    pos = 0;
    while (pos < set_count && set_vals[pos] < v) pos++;
    present = (pos < set_count) && (set_vals[pos] == v);
    r.success = 1'b0;
    r.status = ST_MISS;
    if (op.kind == KIND_INSERT) begin
      if (!present && set_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (!present) begin
        for (int i = set_count; i > pos; i--) set_vals[i] = set_vals[i-1];
        set_vals[pos] = v;
        set_count++;
        r.success = 1'b1;
        r.status = ST_DONE;
      end
    end else if (op.kind == KIND_REMOVE) begin
      if (present) begin
        for (int i = pos; i + 1 < set_count; i++) set_vals[i] = set_vals[i+1];
        set_count--;
        r.success = 1'b1;
        r.status = ST_DONE;
      end
    end else if (present) begin
      r.success = 1'b1;
      r.status = ST_DONE;
    end
    r.entry_count = set_count[COUNT_W-1:0];
    return r;
  endfunction

  // Bursts alternate between filling and draining to drive the table toward both full and empty.
  function automatic op_row_t random_op(int n);
    op_row_t row;
    int      roll;
    row = '0;
    roll = $urandom_range(99);
    if ((n / 24) % 2 == 0) begin
      row.kind = (roll < 65) ? KIND_INSERT : (roll < 80) ? KIND_REMOVE :
                 (roll < 95) ? KIND_LOOKUP : KIND_SPARE;
    end else begin
      row.kind = (roll < 15) ? KIND_INSERT : (roll < 65) ? KIND_REMOVE :
                 (roll < 95) ? KIND_LOOKUP : KIND_SPARE;
    end
    if ($urandom_range(99) < 75) begin
      row.value = value_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      row.value = $urandom();
    end
    return row;
  endfunction

  task automatic drain();
    while (op_queue.size() != 0 || req_valid || pending_rsps.size() != 0) @(negedge clk);
  endtask

  // request side: predict on acceptance, then present the next transaction
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        model_rsp = apply_set_op(req);
        pending_rsps.push_back(cur_typed ? cur_want : model_rsp);
        ops_sent++;
      end
      if (!req_valid || !req_stall) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_row = op_queue.pop_front();
          req_valid <= 1'b1;
          req <= {next_row.kind, next_row.value};
          cur_typed <= next_row.typed;
          cur_want <= {next_row.success, next_row.status, next_row.count};
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response side
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (rsp.status == ST_FULL) full_refusals++;
        if (rsp.entry_count == 0) empty_results++;
        if (pending_rsps.size() == 0) begin
          $error("result with nothing outstanding: success %0d status %0d count %0d",
                 rsp.success, rsp.status, rsp.entry_count);
          error_count++;
        end else begin
          got_want = pending_rsps.pop_front();
          if (rsp.success !== got_want.success) begin
            $error("success: expected %0d, got %0d", got_want.success, rsp.success);
            error_count++;
          end
          if (rsp.status !== got_want.status) begin
            $error("status: expected %0d, got %0d", got_want.status, rsp.status);
            error_count++;
          end
          if (rsp.entry_count !== got_want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", got_want.entry_count,
                   rsp.entry_count);
            error_count++;
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sorted_set_table_core: errors");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) op_queue.push_back(directed_rows[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) op_queue.push_back(random_op(n));
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_rsps.size() != 0) begin
      $error("%0d results never arrived", pending_rsps.size());
      error_count++;
    end
    $display("covered %0d operations and %0d results over four flow-control phases",
             ops_sent, results_seen);
    $display("%0d inserts refused on a full table, %0d results with the table empty",
             full_refusals, empty_results);
    if (error_count == 0) begin
      $display("tb_sorted_set_table_core: clean");
    end else begin
      $display("tb_sorted_set_table_core: errors");
    end
    $finish;
  end

endmodule
